[rtl/core/rcf_pkg.sv]
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types and constants of the clipped rectangle fill engine.
// ----------------------------------------------------------------------------
package rcf_pkg;

	localparam int unsigned COORD_W  = 16;
	localparam int unsigned CLIP_W   = 13;
	localparam int unsigned PITCH_W  = 16;
	localparam int unsigned BPP_W    = 3;
	localparam int unsigned OFFSET_W = 28;
	localparam int unsigned PIX_W    = 12;
	localparam int unsigned COLOR_W  = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH     = 3'd0,
		CFG_FRAME_HEIGHT    = 3'd1,
		CFG_ROW_PITCH       = 3'd2,
		CFG_BYTES_PER_PIXEL = 3'd3
	} cfg_idx_t;

	localparam logic [CLIP_W-1:0]  RST_FRAME_WIDTH     = 13'd640;
	localparam logic [CLIP_W-1:0]  RST_FRAME_HEIGHT    = 13'd480;
	localparam logic [PITCH_W-1:0] RST_ROW_PITCH       = 16'd2560;
	localparam logic [BPP_W-1:0]   RST_BYTES_PER_PIXEL = 3'd4;

	typedef struct packed {
		logic                      opcode;
		logic signed [COORD_W-1:0] corner_min_x;
		logic signed [COORD_W-1:0] corner_min_y;
		logic signed [COORD_W-1:0] corner_max_x;
		logic signed [COORD_W-1:0] corner_max_y;
		logic                      outline_only;
		logic [7:0]                color_red;
		logic [7:0]                color_green;
		logic [7:0]                color_blue;
		logic [7:0]                color_alpha;
	} cmd_word_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] pixel_offset;
		logic [PIX_W-1:0]    pixel_x;
		logic [PIX_W-1:0]    pixel_y;
		logic [COLOR_W-1:0]  pixel_color;
		logic                last_pixel;
	} pix_word_t;

	typedef struct packed {
		logic [CLIP_W-1:0]  frame_width;
		logic [CLIP_W-1:0]  frame_height;
		logic [PITCH_W-1:0] row_pitch;
		logic [BPP_W-1:0]   bytes_per_pixel;
	} cfg_regs_t;

	// one pixel write request from the scan stage to the output stage
	typedef struct packed {
		logic               write;
		logic [CLIP_W-1:0]  x;
		logic [CLIP_W-1:0]  y;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pix_req_t;

	// clamp a signed corner coordinate to [0, limit]
	function automatic logic [CLIP_W-1:0] clamp_side(
		input logic signed [COORD_W-1:0] v,
		input logic [CLIP_W-1:0]         limit
	);
		logic [CLIP_W-1:0] r;
		if (v[COORD_W-1]) begin
			r = '0;
		end else if (v > $signed({{(COORD_W-CLIP_W){1'b0}}, limit})) begin
			r = limit;
		end else begin
			r = v[CLIP_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/rcf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rcf_cfg_regs
// Frame geometry registers written through the configuration channel.
// ----------------------------------------------------------------------------
module rcf_cfg_regs
	import rcf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_regs_t             regs
);

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.frame_width     <= RST_FRAME_WIDTH;
			regs_q.frame_height    <= RST_FRAME_HEIGHT;
			regs_q.row_pitch       <= RST_ROW_PITCH;
			regs_q.bytes_per_pixel <= RST_BYTES_PER_PIXEL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH:     regs_q.frame_width     <= cfg_data[CLIP_W-1:0];
				CFG_FRAME_HEIGHT:    regs_q.frame_height    <= cfg_data[CLIP_W-1:0];
				CFG_ROW_PITCH:       regs_q.row_pitch       <= cfg_data[PITCH_W-1:0];
				CFG_BYTES_PER_PIXEL: regs_q.bytes_per_pixel <= cfg_data[BPP_W-1:0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

endmodule

[rtl/core/rcf_scan.sv]
// ----------------------------------------------------------------------------
// rcf_scan
// Command register and scan state: latches clipped rectangles, walks the
// cursor one pixel per step word and issues pixel write requests.
// ----------------------------------------------------------------------------
module rcf_scan
	import rcf_pkg::*;
#(
	parameter int unsigned MAX_FRAME_SIDE = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd_word,
	input  cfg_regs_t regs,
	input  logic      out_free,
	output pix_req_t  req
);

	localparam int unsigned LIM_W = CLIP_W + 2;

	cmd_word_t         cmd_s1;
	logic              valid_s1;
	logic              advance;
	logic              do_load;
	logic              do_step;

	logic              scan_active_q;
	logic [CLIP_W-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
	logic [CLIP_W-1:0] cursor_x_q, cursor_y_q;
	logic [COLOR_W-1:0] packed_color_q;
	logic              outline_mode_q;

	logic [CLIP_W-1:0] lim_w, lim_h;
	logic [CLIP_W-1:0] new_left, new_top, new_right, new_bottom;
	logic [CLIP_W:0]   x_p1, y_p1;
	logic              row_end, last, border;

	assign cmd_stall = valid_s1 && !out_free;
	assign advance   = valid_s1 && out_free;
	assign do_load   = advance && (cmd_s1.opcode == OP_LOAD);
	assign do_step   = advance && (cmd_s1.opcode == OP_STEP) && scan_active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_stall || cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd_word;
		end
	end

	// frame size above the parameter limit clips at the limit
	always_comb begin
		lim_w = ({2'b00, regs.frame_width} > LIM_W'(MAX_FRAME_SIDE))
			? CLIP_W'(MAX_FRAME_SIDE) : regs.frame_width;
		lim_h = ({2'b00, regs.frame_height} > LIM_W'(MAX_FRAME_SIDE))
			? CLIP_W'(MAX_FRAME_SIDE) : regs.frame_height;
		new_left   = clamp_side(cmd_s1.corner_min_x, lim_w);
		new_top    = clamp_side(cmd_s1.corner_min_y, lim_h);
		new_right  = clamp_side(cmd_s1.corner_max_x, lim_w);
		new_bottom = clamp_side(cmd_s1.corner_max_y, lim_h);
	end

	always_comb begin
		x_p1    = {1'b0, cursor_x_q} + 1'b1;
		y_p1    = {1'b0, cursor_y_q} + 1'b1;
		row_end = x_p1 >= {1'b0, clip_right_q};
		last    = row_end && (y_p1 >= {1'b0, clip_bottom_q});
		border  = (cursor_y_q == clip_top_q) || (y_p1 == {1'b0, clip_bottom_q}) ||
			(cursor_x_q == clip_left_q) || (x_p1 == {1'b0, clip_right_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_active_q  <= 1'b0;
			clip_left_q    <= '0;
			clip_top_q     <= '0;
			clip_right_q   <= '0;
			clip_bottom_q  <= '0;
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			packed_color_q <= '0;
			outline_mode_q <= 1'b0;
		end else if (do_load) begin
			clip_left_q    <= new_left;
			clip_top_q     <= new_top;
			clip_right_q   <= new_right;
			clip_bottom_q  <= new_bottom;
			cursor_x_q     <= new_left;
			cursor_y_q     <= new_top;
			packed_color_q <= {cmd_s1.color_alpha, cmd_s1.color_red,
				cmd_s1.color_green, cmd_s1.color_blue};
			outline_mode_q <= cmd_s1.outline_only;
			scan_active_q  <= (new_left < new_right) && (new_top < new_bottom);
		end else if (do_step) begin
			priority if (last) begin
				scan_active_q <= 1'b0;
			end else if (row_end) begin
				cursor_x_q <= clip_left_q;
				cursor_y_q <= y_p1[CLIP_W-1:0];
			end else begin
				cursor_x_q <= x_p1[CLIP_W-1:0];
			end
		end
	end

	assign req.write = do_step && (!outline_mode_q || border);
	assign req.x     = cursor_x_q;
	assign req.y     = cursor_y_q;
	assign req.color = packed_color_q;
	assign req.last  = last;

	a_cursor_below_end: assert property (@(posedge clk) disable iff (!arst_n)
		scan_active_q |-> (cursor_x_q < clip_right_q) && (cursor_y_q < clip_bottom_q))
		else $error("scan cursor past the clipped rectangle");

	a_cursor_above_start: assert property (@(posedge clk) disable iff (!arst_n)
		scan_active_q |-> (cursor_x_q >= clip_left_q) && (cursor_y_q >= clip_top_q))
		else $error("scan cursor before the clipped rectangle");

	a_last_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(do_step && last) |=> !scan_active_q)
		else $error("scan still active after its last pixel");

	a_write_needs_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req.write |-> scan_active_q && valid_s1 && out_free)
		else $error("pixel request without an active scan step");

endmodule

[rtl/core/rcf_pixel_out.sv]
// ----------------------------------------------------------------------------
// rcf_pixel_out
// Byte offset computation and output register of the pixel write channel.
// ----------------------------------------------------------------------------
module rcf_pixel_out
	import rcf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pix_req_t  req,
	input  cfg_regs_t regs,
	output logic      out_free,
	output logic      pix_valid,
	input  logic      pix_stall,
	output pix_word_t pix_word
);

	logic [CLIP_W+PITCH_W-1:0] row_off;
	logic [CLIP_W+BPP_W-1:0]   col_off;
	logic [CLIP_W+PITCH_W-1:0] sum_off;
	logic                      pix_valid_q;
	pix_word_t                 pix_word_q;

	assign out_free  = !pix_valid_q || !pix_stall;
	assign pix_valid = pix_valid_q;
	assign pix_word  = pix_word_q;

	always_comb begin
		row_off = req.y * regs.row_pitch;
		col_off = req.x * regs.bytes_per_pixel;
		sum_off = row_off + (CLIP_W+PITCH_W)'(col_off);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (out_free) begin
			pix_valid_q <= req.write;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && req.write) begin
			pix_word_q.pixel_offset <= sum_off[OFFSET_W-1:0];
			pix_word_q.pixel_x      <= req.x[PIX_W-1:0];
			pix_word_q.pixel_y      <= req.y[PIX_W-1:0];
			pix_word_q.pixel_color  <= req.color;
			pix_word_q.last_pixel   <= req.last;
		end
	end

endmodule

[rtl/core/clipped_rectangle_fill_engine.sv]
// ----------------------------------------------------------------------------
// clipped_rectangle_fill_engine
// Rectangle fill engine: clips a rectangle to the frame and turns step words
// into pixel writes (offset, coordinates, colour), at most one per step.
// ----------------------------------------------------------------------------
//
//   channel  handshake              word        carries
//   cmd      cmd_valid / cmd_stall  cmd_word    load or step command
//   pix      pix_valid / pix_stall  pix_word    one pixel write
//   cfg      cfg_valid / cfg_ready  cfg_index,  frame geometry register write
//                                   cfg_data
//
// One command word is taken per clock while cmd_stall is low. A taken word
// is held in the command register; the scan state and the offset multiply
// (row * pitch + col * bpp) then settle it into the pixel output register,
// from which its write shows on pix. Load words, steps while no scan is
// active and steps that land on outline interior pixels give no write.
// Reset (arst_n low) clears the scan, empties both registers and restores
// the geometry registers to 640 x 480, pitch 2560, 4 bytes per pixel.
// A stall on pix with pix_valid high holds the output register and a word in
// the command register; cmd_stall rises in the same cycle so none is dropped.
//
module clipped_rectangle_fill_engine
	import rcf_pkg::*;
#(
	parameter int unsigned MAX_FRAME_SIDE = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  cmd_word_t             cmd_word,
	output logic                  pix_valid,
	input  logic                  pix_stall,
	output pix_word_t             pix_word,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_regs_t regs;
	pix_req_t  req;
	logic      out_free;

	// geometry registers
	rcf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// command register, clipping and scan cursor
	rcf_scan #(
		.MAX_FRAME_SIDE (MAX_FRAME_SIDE)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.regs      (regs),
		.out_free  (out_free),
		.req       (req)
	);

	// offset math and pixel output register
	rcf_pixel_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.regs      (regs),
		.out_free  (out_free),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_word  (pix_word)
	);

endmodule
